### design/chsi_pkg.sv
// Shared types, codes and constants of the cubic Hermite sample interpolator.
`timescale 1ns / 1ps
package chsi_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int SAMPLE_W        = 24;
    localparam int POS_W           = 28;
    localparam int INDEX_W         = 8;
    localparam int COUNT_W         = 9;
    localparam int RESULT_W        = 32;
    localparam int OP_W            = 2;
    localparam int IN_DATA_W       = 64;
    localparam int COUNT_RESET     = 256;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_VALUE = 2'd1;
    localparam logic [OP_W-1:0] OP_DERIV = 2'd2;

    // table read address choice
    typedef enum logic [2:0] {
        RA_M1 = 3'd0,
        RA_0  = 3'd1,
        RA_1  = 3'd2,
        RA_2  = 3'd3,
        RA_X  = 3'd4
    } rd_sel_t;

    typedef enum logic [1:0] {
        CAP_NONE = 2'd0,
        CAP_M1   = 2'd1,
        CAP_0    = 2'd2,
        CAP_1    = 2'd3
    } cap_sel_t;

    typedef enum logic [1:0] {
        MS_C3 = 2'd0,
        MS_LO = 2'd1,
        MS_HI = 2'd2
    } mul_src_t;

    typedef enum logic [1:0] {
        AO_HOLD = 2'd0,
        AO_LOAD = 2'd1,
        AO_ADD  = 2'd2
    } acc_op_t;

    typedef enum logic [1:0] {
        K_C2 = 2'd0,
        K_M0 = 2'd1,
        K_D0 = 2'd2
    } k_sel_t;

    typedef struct packed {
        logic     accept;
        logic     rd_en;
        rd_sel_t  rd_sel;
        cap_sel_t cap_sel;
        logic     coef_en;
        mul_src_t mul_src;
        acc_op_t  acc_op;
        k_sel_t   k_sel;
        logic     out_ld_int;
        logic     out_ld_ext;
    } dp_cmd_t;

    typedef struct packed {
        logic in_query;
        logic in_extrap;
        logic deriv;
        logic out_free;
    } dp_sts_t;

endpackage

### design/chsi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module chsi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/chsi_ctrl.sv
// Sequencer: walks interpolated queries through reads, coefficients and multiplies.
`timescale 1ns / 1ps
module chsi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  chsi_pkg::dp_sts_t sts,
    output chsi_pkg::dp_cmd_t cmd
);
    import chsi_pkg::*;

    typedef enum logic [16:0] {
        ST_IDLE = 17'h00001,
        ST_RM1  = 17'h00002,
        ST_R0   = 17'h00004,
        ST_R1   = 17'h00008,
        ST_R2   = 17'h00010,
        ST_COEF = 17'h00020,
        ST_MC3  = 17'h00040,
        ST_ACC1 = 17'h00080,
        ST_L1   = 17'h00100,
        ST_H1   = 17'h00200,
        ST_A2   = 17'h00400,
        ST_L2   = 17'h00800,
        ST_H2   = 17'h01000,
        ST_A3   = 17'h02000,
        ST_OUT  = 17'h04000,
        ST_XRD  = 17'h08000,
        ST_XOUT = 17'h10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = RA_0;
        cmd.cap_sel    = CAP_NONE;
        cmd.mul_src    = MS_C3;
        cmd.acc_op     = AO_HOLD;
        cmd.k_sel      = K_C2;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && sts.in_query)
                begin
                    state_next = sts.in_extrap ? ST_XRD : ST_RM1;
                end
            end
            ST_RM1:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RA_M1;
                state_next = ST_R0;
            end
            ST_R0:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RA_0;
                cmd.cap_sel = CAP_M1;
                state_next  = ST_R1;
            end
            ST_R1:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RA_1;
                cmd.cap_sel = CAP_0;
                state_next  = ST_R2;
            end
            ST_R2:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RA_2;
                cmd.cap_sel = CAP_1;
                state_next  = ST_COEF;
            end
            ST_COEF:
            begin
                cmd.coef_en = 1'b1;
                state_next  = ST_MC3;
            end
            ST_MC3:
            begin
                cmd.mul_src = MS_C3;
                state_next  = ST_ACC1;
            end
            ST_ACC1:
            begin
                cmd.acc_op = AO_LOAD;
                cmd.k_sel  = K_C2;
                state_next = ST_L1;
            end
            ST_L1:
            begin
                cmd.mul_src = MS_LO;
                state_next  = ST_H1;
            end
            ST_H1:
            begin
                cmd.mul_src = MS_HI;
                cmd.acc_op  = AO_LOAD;
                cmd.k_sel   = K_M0;
                state_next  = ST_A2;
            end
            ST_A2:
            begin
                cmd.acc_op = AO_ADD;
                state_next = sts.deriv ? ST_OUT : ST_L2;
            end
            ST_L2:
            begin
                cmd.mul_src = MS_LO;
                state_next  = ST_H2;
            end
            ST_H2:
            begin
                cmd.mul_src = MS_HI;
                cmd.acc_op  = AO_LOAD;
                cmd.k_sel   = K_D0;
                state_next  = ST_A3;
            end
            ST_A3:
            begin
                cmd.acc_op = AO_ADD;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_ld_int = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_XRD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RA_X;
                state_next = ST_XOUT;
            end
            ST_XOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_ld_ext = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/chsi_dpath.sv
// Datapath: sample table, count register, coefficients, shared multiplier, output register.
`timescale 1ns / 1ps
module chsi_dpath #(
    parameter int TABLE_DEPTH = chsi_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [chsi_pkg::COUNT_W-1:0]    cfg_wr_data,
    input  logic [chsi_pkg::IN_DATA_W-1:0]  in_tdata,
    input  logic [chsi_pkg::OP_W-1:0]       in_tuser,
    input  chsi_pkg::dp_cmd_t               cmd,
    output chsi_pkg::dp_sts_t               sts,
    output logic                            out_tvalid,
    input  logic                            out_tready,
    output logic [chsi_pkg::RESULT_W-1:0]   out_tdata,
    output logic                            out_tuser
);
    import chsi_pkg::*;

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int IW  = ((AW > COUNT_W) ? AW : COUNT_W) + 1;
    localparam int ACW = 81;
    localparam logic [IW-1:0] DEPTH_W = IW'(TABLE_DEPTH);
    localparam logic signed [ACW-1:0] SAT_MAX = 81'sd2147483647;
    localparam logic signed [ACW-1:0] SAT_MIN = -81'sd2147483648;

    // input fields
    logic [INDEX_W-1:0]         in_index;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic signed [POS_W-1:0]    in_pos;

    assign in_index  = in_tdata[7:0];
    assign in_sample = $signed(in_tdata[31:8]);
    assign in_pos    = $signed(in_tdata[59:32]);

    // count register and clamped n-1
    logic [COUNT_W-1:0] count_reg;
    logic [IW-1:0]      n_w;
    logic [IW-1:0]      nm1_w;
    logic signed [IW+16:0] lim_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_W'(COUNT_RESET);
        end
        else if (cfg_wr_en)
        begin
            count_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        if (count_reg < COUNT_W'(2))
        begin
            n_w = IW'(2);
        end
        else if (IW'(count_reg) > DEPTH_W)
        begin
            n_w = DEPTH_W;
        end
        else
        begin
            n_w = IW'(count_reg);
        end
    end

    assign nm1_w = n_w - IW'(1);
    assign lim_w = $signed({1'b0, nm1_w, 16'h0000});

    // item registers
    logic                    deriv_reg;
    logic                    below_reg;
    logic signed [POS_W-1:0] pos_reg;
    logic [IW-1:0]           i0_reg;
    logic [15:0]             frac_w;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            deriv_reg <= (in_tuser == OP_DERIV);
            below_reg <= in_pos[POS_W-1];
            pos_reg   <= in_pos;
            i0_reg    <= IW'(in_pos[26:16]);
        end
    end

    assign frac_w = pos_reg[15:0];

    assign sts.in_query  = (in_tuser == OP_VALUE) || (in_tuser == OP_DERIV);
    assign sts.in_extrap = in_pos[POS_W-1] || (in_pos >= lim_w);
    assign sts.deriv     = deriv_reg;

    // sample table
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [IW-1:0]       raddr_w;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic [IW-1:0]       i0p1_w;

    assign ram_we    = cmd.accept && (in_tuser == OP_WRITE) && (IW'(in_index) < DEPTH_W);
    assign ram_waddr = AW'(in_index);
    assign i0p1_w    = i0_reg + IW'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            RA_M1:   raddr_w = (i0_reg == '0) ? '0 : i0_reg - IW'(1);
            RA_0:    raddr_w = i0_reg;
            RA_1:    raddr_w = i0p1_w;
            RA_2:    raddr_w = (i0p1_w == nm1_w) ? i0p1_w : i0_reg + IW'(2);
            RA_X:    raddr_w = below_reg ? '0 : nm1_w;
            default: raddr_w = i0_reg;
        endcase
    end

    chsi_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_sample),
        .re    (cmd.rd_en),
        .raddr (AW'(raddr_w)),
        .rdata (ram_rdata)
    );

    // captured samples
    logic signed [SAMPLE_W-1:0] sm1_reg;
    logic signed [SAMPLE_W-1:0] s0_reg;
    logic signed [SAMPLE_W-1:0] s1_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.cap_sel)
            CAP_M1:  sm1_reg <= $signed(ram_rdata);
            CAP_0:   s0_reg  <= $signed(ram_rdata);
            CAP_1:   s1_reg  <= $signed(ram_rdata);
            default: ;
        endcase
    end

    // coefficients; tangents kept doubled
    logic signed [31:0] d10_w;
    logic signed [31:0] m0_w;
    logic signed [31:0] m1_w;
    logic signed [31:0] c3_w;
    logic signed [31:0] c3x_w;
    logic signed [31:0] c2_w;
    logic signed [26:0] m0_reg;
    logic signed [30:0] c3x_reg;
    logic signed [29:0] c2_reg;

    always_comb
    begin
        d10_w = 32'(s1_reg) - 32'(s0_reg);
        m0_w  = (i0_reg == '0) ? (d10_w <<< 1) : 32'(s1_reg) - 32'(sm1_reg);
        m1_w  = (i0p1_w == nm1_w) ? (d10_w <<< 1)
                                  : 32'($signed(ram_rdata)) - 32'(s0_reg);
        c3_w  = m0_w + m1_w - (d10_w <<< 2);
        c3x_w = deriv_reg ? c3_w + (c3_w <<< 1) : c3_w;
        c2_w  = (d10_w <<< 2) + (d10_w <<< 1) - (m0_w <<< 1) - m1_w;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.coef_en)
        begin
            m0_reg  <= 27'(m0_w);
            c3x_reg <= 31'(c3x_w);
            c2_reg  <= 30'(c2_w);
        end
    end

    // shared multiplier by the fraction, then accumulator
    logic signed [32:0]    mul_a_w;
    logic signed [49:0]    prod_w;
    logic signed [49:0]    prod_reg;
    logic signed [ACW-1:0] acc_reg;
    logic signed [ACW-1:0] k_w;

    always_comb
    begin
        case (cmd.mul_src)
            MS_C3:   mul_a_w = 33'(c3x_reg);
            MS_LO:   mul_a_w = $signed({1'b0, acc_reg[31:0]});
            MS_HI:   mul_a_w = $signed(acc_reg[64:32]);
            default: mul_a_w = 33'(c3x_reg);
        endcase
        prod_w = mul_a_w * $signed({1'b0, frac_w});
    end

    always_comb
    begin
        case (cmd.k_sel)
            K_C2:    k_w = deriv_reg ? (ACW'(c2_reg) <<< 17) : (ACW'(c2_reg) <<< 16);
            K_M0:    k_w = (ACW'(m0_reg) <<< 32)
                           + (deriv_reg ? (81'sd1 <<< 32) : 81'sd0);
            K_D0:    k_w = ACW'($signed({s0_reg, 1'b1})) <<< 48;
            default: k_w = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_w;
        case (cmd.acc_op)
            AO_LOAD: acc_reg <= ACW'(prod_reg) + k_w;
            AO_ADD:  acc_reg <= acc_reg + (ACW'(prod_reg) <<< 32);
            default: ;
        endcase
    end

    // result formation
    logic signed [ACW-1:0]      sh_w;
    logic signed [RESULT_W-1:0] int_res_w;
    logic signed [RESULT_W-1:0] ext_res_w;

    always_comb
    begin
        sh_w = deriv_reg ? (acc_reg >>> 33) : (acc_reg >>> 49);
        if (sh_w > SAT_MAX)
        begin
            int_res_w = 32'sh7fffffff;
        end
        else if (sh_w < SAT_MIN)
        begin
            int_res_w = 32'sh80000000;
        end
        else
        begin
            int_res_w = sh_w[RESULT_W-1:0];
        end

        if (below_reg)
        begin
            ext_res_w = deriv_reg ? -32'sd65536
                                  : 32'($signed(ram_rdata)) - 32'(pos_reg);
        end
        else
        begin
            ext_res_w = deriv_reg ? 32'sd65536
                                  : 32'(pos_reg) - 32'(lim_w) + 32'($signed(ram_rdata));
        end
    end

    // output register
    logic                out_valid_reg;
    logic [RESULT_W-1:0] out_data_reg;
    logic                out_ext_reg;

    assign sts.out_free = !out_valid_reg || out_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_ld_int || cmd.out_ld_ext)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld_int)
        begin
            out_data_reg <= int_res_w;
            out_ext_reg  <= 1'b0;
        end
        else if (cmd.out_ld_ext)
        begin
            out_data_reg <= ext_res_w;
            out_ext_reg  <= 1'b1;
        end
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = out_data_reg;
    assign out_tuser  = out_ext_reg;

    // a result is only loaded into a free output slot
    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_ld_int || cmd.out_ld_ext) |-> (!out_valid_reg || out_tready))
        else $error("result loaded over an untaken result");

    // table writes never collide with table reads
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !cmd.rd_en)
        else $error("table write during a read step");

    // interpolation only between in-range neighbors
    a_i0_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.coef_en |-> (i0_reg < nm1_w))
        else $error("interpolation segment past the last sample");

endmodule

### design/cubic_hermite_sample_interp_core.sv
// Top level of the cubic Hermite (Catmull-Rom tangent) sample interpolator.
//
// Usage:
//   Input items arrive on s_axis. tuser carries the op: write sample, query
//   value or query derivative. A write stores sample_value at sample_index and
//   gives no result. A query gives one result item on m_axis:
//   tdata is the saturated Q15.16 value or slope, tuser is set when the
//   position fell outside [0, n-1) and the result was extrapolated linearly.
//   cfg_wr_en/cfg_wr_data set the sample count; write it only while idle.
// Sequencing (one item in flight, sequencer-bound): a write is taken in idle;
//   an extrapolated query makes one table read and then loads its result; an
//   interpolated query makes four table reads through the single read port,
//   then multiply steps on one shared 33x17 multiplier with a registered
//   product; a value query runs more multiply steps than a derivative query.
//   A query result is loaded into the output register after its last step.
// Reset: sequencer idle, output empty, sample count back to 256. The table
//   is not cleared; queries must only touch written entries.
// Stall: a finished result waits in the output register; the block goes on
//   taking the next item and holds a later result until the slot frees.
`timescale 1ns / 1ps
module cubic_hermite_sample_interp_core #(
    parameter int TABLE_DEPTH = chsi_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [chsi_pkg::COUNT_W-1:0]   cfg_wr_data,   // sample_count
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] sample_index, [31:8] sample_value, [59:32] position, [63:60] zero
    input  logic [chsi_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic [chsi_pkg::OP_W-1:0]      s_axis_tuser,  // [1:0] op
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [chsi_pkg::RESULT_W-1:0]  m_axis_tdata,  // [31:0] result_value
    output logic                           m_axis_tuser   // [0] extrapolated
);
    import chsi_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer
    chsi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table, arithmetic and output register
    chsi_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_tdata    (s_axis_tdata),
        .in_tuser    (s_axis_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .out_tvalid  (m_axis_tvalid),
        .out_tready  (m_axis_tready),
        .out_tdata   (m_axis_tdata),
        .out_tuser   (m_axis_tuser)
    );

endmodule
